>>> rtl/core/olpt_pkg.sv
package olpt_pkg;

	// Width of the probe count and stored count result fields.
	localparam int PW = 11;

	// Operation codes.
	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_ERASE  = 2'd2;

	// Slot kinds.
	localparam logic [1:0] KIND_EMPTY   = 2'd0;
	localparam logic [1:0] KIND_PRESENT = 2'd1;
	localparam logic [1:0] KIND_TOMB    = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_DUP      = 3'd1;
	localparam logic [2:0] ST_ERASED   = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_FOUND    = 3'd4;
	localparam logic [2:0] ST_FULL     = 3'd5;
	localparam logic [2:0] ST_OVERFLOW = 3'd6;

	// Back end sequencer states.
	typedef enum logic [2:0] {
		BS_CLEAR,
		BS_IDLE,
		BS_ISSUE,
		BS_WALK,
		BS_HOME
	} back_state_t;

	// Status the back end reports to the front end.
	typedef struct packed {
		logic clearing;
		logic ready;
	} back_stat_t;

endpackage

>>> rtl/core/olpt_home.sv
// Home slot of a key: floor(key * HOME_SLOTS / 2^64).
// The two partial products are registered; the sum is formed combinationally from them.
module olpt_home #(
	parameter int HOME_SLOTS = 1024,
	parameter int IW = 11
) (
	input  logic          clk,
	input  logic [63:0]   key,
	output logic [IW-1:0] home
);
	localparam int HW = $clog2(HOME_SLOTS + 1);
	localparam int MW = 32 + HW;

	logic [MW-1:0] ph_q;
	logic [MW-1:0] pl_q;
	logic [MW:0]   sum;

	// Partial products of the high and low key halves.
	always_ff @(posedge clk) begin
		ph_q <= MW'(key[63:32]) * MW'(HOME_SLOTS);
		pl_q <= MW'(key[31:0]) * MW'(HOME_SLOTS);
	end

	// Combine the halves and keep the bits above 2^32.
	assign sum  = {1'b0, ph_q} + {1'b0, (pl_q >> 32)};
	assign home = IW'(sum >> 32);
endmodule

>>> rtl/core/olpt_front.sv
// Front end: takes commands, computes the home slot and queues the beats.
module olpt_front #(
	parameter int HOME_SLOTS = 1024,
	parameter int IW = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          op,
	input  logic [63:0]         key,
	input  olpt_pkg::back_stat_t bstat,
	input  logic                pop,
	output logic                busy,
	output logic                q_valid,
	output logic [1:0]          q_op,
	output logic [63:0]         q_key,
	output logic [IW-1:0]       q_home
);
	localparam int QD = 2;

	logic          v_s1;
	logic [1:0]    op_s1;
	logic [63:0]   key_s1;
	logic [IW-1:0] home_s1;
	logic          take;

	logic [1:0]    q_op_q   [QD];
	logic [63:0]   q_key_q  [QD];
	logic [IW-1:0] q_home_q [QD];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;

	olpt_home #(.HOME_SLOTS(HOME_SLOTS), .IW(IW)) u_home (
		.clk  (clk),
		.key  (key),
		.home (home_s1)
	);

	// Hold off while the table clears or when the queue could not take the beat.
	assign busy = bstat.clearing || ((cnt_q + 2'(v_s1)) >= 2'(QD));
	assign take = start && !busy;

	// Stage one: the command waits here while its home slot is formed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1  <= op;
			key_s1 <= key;
		end
	end

	// Two-entry queue between the front and back ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (v_s1) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(v_s1) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			q_op_q[wr_ptr_q]   <= op_s1;
			q_key_q[wr_ptr_q]  <= key_s1;
			q_home_q[wr_ptr_q] <= home_s1;
		end
	end

	assign q_valid = (cnt_q != 2'd0);
	assign q_op    = q_op_q[rd_ptr_q];
	assign q_key   = q_key_q[rd_ptr_q];
	assign q_home  = q_home_q[rd_ptr_q];
endmodule

>>> rtl/core/olpt_back.sv
// Back end: walks the slot memories one slot a cycle and writes the result.
module olpt_back #(
	parameter int HOME_SLOTS = 1024,
	parameter int OVERFLOW_SLOTS = 64,
	parameter int IW = 11
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  logic [1:0]           q_op,
	input  logic [63:0]          q_key,
	input  logic [IW-1:0]        q_home,
	output logic                 pop,
	output olpt_pkg::back_stat_t bstat,
	output logic                 done,
	output logic [2:0]           status,
	output logic [olpt_pkg::PW-1:0] probe_count,
	output logic [olpt_pkg::PW-1:0] stored_count
);
	localparam int TOTAL = HOME_SLOTS + OVERFLOW_SLOTS;
	localparam int CW = $clog2(HOME_SLOTS + 1);
	localparam int PW = olpt_pkg::PW;

	olpt_pkg::back_state_t state_q, state_d;

	logic [1:0]    op_q;
	logic [63:0]   key_q;
	logic [63:0]   carry_q;
	logic [IW-1:0] home_q;
	logic [IW-1:0] idx_q;
	logic [PW-1:0] n_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] clr_q;
	logic          commit_q;
	logic          done_q;
	logic [2:0]    status_q;
	logic [PW-1:0] probe_q;

	// Slot memories with two registered read ports.
	logic [1:0]  kind_mem [TOTAL];
	logic [63:0] key_mem  [TOTAL];
	logic [1:0]  kind_a, kind_b;
	logic [63:0] key_a, key_b;
	logic [IW-1:0] rd_idx, rd_nxt;

	logic [IW-1:0] home_b;

	// Decisions of the current cycle.
	logic          fin;
	logic [2:0]    fin_st;
	logic [PW-1:0] fin_probe;
	logic          start_walk;
	logic          adv;
	logic          restart;
	logic          to_home;
	logic          take_carry;
	logic          wkey;
	logic          wkind;
	logic [1:0]    wkind_val;
	logic          cinc;
	logic          cdec;
	logic [PW-1:0] n1;
	logic          last;
	logic          next_free;
	logic          ins;

	// Home slot of the key following an erased slot.
	olpt_home #(.HOME_SLOTS(HOME_SLOTS), .IW(IW)) u_home (
		.clk  (clk),
		.key  (key_b),
		.home (home_b)
	);

	assign rd_idx = (state_q == olpt_pkg::BS_WALK) ? IW'(idx_q + 1'b1) : idx_q;
	assign rd_nxt = IW'(rd_idx + 1'b1);

	assign n1        = n_q + 1'b1;
	assign last      = (idx_q == IW'(TOTAL - 1));
	assign next_free = last || (kind_b == olpt_pkg::KIND_EMPTY);
	assign ins       = (op_q == olpt_pkg::OP_INSERT);

	// Decide what the current cycle does.
	always_comb begin
		fin        = 1'b0;
		fin_st     = olpt_pkg::ST_NOTFOUND;
		fin_probe  = n1;
		start_walk = 1'b0;
		adv        = 1'b0;
		restart    = 1'b0;
		to_home    = 1'b0;
		take_carry = 1'b0;
		wkey       = 1'b0;
		wkind      = 1'b0;
		wkind_val  = olpt_pkg::KIND_EMPTY;
		cinc       = 1'b0;
		cdec       = 1'b0;
		pop        = 1'b0;
		case (state_q)
			olpt_pkg::BS_IDLE: begin
				if (q_valid) begin
					pop       = 1'b1;
					fin_probe = '0;
					if (q_op == olpt_pkg::OP_INSERT && cnt_q >= CW'(HOME_SLOTS)) begin
						fin    = 1'b1;
						fin_st = olpt_pkg::ST_FULL;
					end else if (q_op != olpt_pkg::OP_LOOKUP && q_op != olpt_pkg::OP_INSERT
						&& q_op != olpt_pkg::OP_ERASE) begin
						fin    = 1'b1;
						fin_st = olpt_pkg::ST_NOTFOUND;
					end else begin
						start_walk = 1'b1;
					end
				end
			end
			olpt_pkg::BS_WALK: begin
				case (kind_a)
					olpt_pkg::KIND_PRESENT: begin
						if (carry_q == key_a) begin
							if (ins) begin
								fin    = 1'b1;
								fin_st = olpt_pkg::ST_DUP;
							end else if (op_q == olpt_pkg::OP_LOOKUP) begin
								fin    = 1'b1;
								fin_st = olpt_pkg::ST_FOUND;
							end else if (next_free) begin
								fin       = 1'b1;
								fin_st    = olpt_pkg::ST_ERASED;
								wkind     = 1'b1;
								wkind_val = olpt_pkg::KIND_EMPTY;
								cdec      = 1'b1;
							end else begin
								to_home = 1'b1;
							end
						end else if (carry_q < key_a) begin
							if (ins) begin
								wkey       = commit_q;
								take_carry = 1'b1;
								adv        = 1'b1;
							end else begin
								fin    = 1'b1;
								fin_st = olpt_pkg::ST_NOTFOUND;
							end
						end else begin
							adv = 1'b1;
						end
					end
					olpt_pkg::KIND_TOMB: begin
						if (ins) begin
							if (carry_q <= key_a || next_free || key_b > carry_q) begin
								if (commit_q) begin
									fin       = 1'b1;
									fin_st    = olpt_pkg::ST_INSERTED;
									wkey      = 1'b1;
									wkind     = 1'b1;
									wkind_val = olpt_pkg::KIND_PRESENT;
									cinc      = 1'b1;
								end else begin
									restart = 1'b1;
								end
							end else begin
								adv = 1'b1;
							end
						end else if (carry_q <= key_a) begin
							fin    = 1'b1;
							fin_st = olpt_pkg::ST_NOTFOUND;
						end else begin
							adv = 1'b1;
						end
					end
					default: begin
						if (ins) begin
							if (commit_q) begin
								fin       = 1'b1;
								fin_st    = olpt_pkg::ST_INSERTED;
								wkey      = 1'b1;
								wkind     = 1'b1;
								wkind_val = olpt_pkg::KIND_PRESENT;
								cinc      = 1'b1;
							end else begin
								restart = 1'b1;
							end
						end else begin
							fin    = 1'b1;
							fin_st = olpt_pkg::ST_NOTFOUND;
						end
					end
				endcase
				// Walking off the last slot ends the operation.
				if (adv && last) begin
					adv    = 1'b0;
					fin    = 1'b1;
					fin_st = ins ? olpt_pkg::ST_OVERFLOW : olpt_pkg::ST_NOTFOUND;
				end
			end
			olpt_pkg::BS_HOME: begin
				fin       = 1'b1;
				fin_st    = olpt_pkg::ST_ERASED;
				fin_probe = n_q;
				wkind     = 1'b1;
				wkind_val = ({1'b0, home_b} == ({1'b0, idx_q} + 1'b1))
					? olpt_pkg::KIND_EMPTY : olpt_pkg::KIND_TOMB;
				cdec      = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			olpt_pkg::BS_CLEAR: begin
				if (clr_q == IW'(TOTAL - 1)) begin
					state_d = olpt_pkg::BS_IDLE;
				end
			end
			olpt_pkg::BS_IDLE: begin
				if (start_walk) begin
					state_d = olpt_pkg::BS_ISSUE;
				end
			end
			olpt_pkg::BS_ISSUE: begin
				state_d = olpt_pkg::BS_WALK;
			end
			olpt_pkg::BS_WALK: begin
				if (fin) begin
					state_d = olpt_pkg::BS_IDLE;
				end else if (restart) begin
					state_d = olpt_pkg::BS_ISSUE;
				end else if (to_home) begin
					state_d = olpt_pkg::BS_HOME;
				end
			end
			olpt_pkg::BS_HOME: begin
				state_d = olpt_pkg::BS_IDLE;
			end
			default: begin
				state_d = olpt_pkg::BS_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= olpt_pkg::BS_CLEAR;
			clr_q   <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (state_q == olpt_pkg::BS_CLEAR) begin
				clr_q <= IW'(clr_q + 1'b1);
			end
			if (cinc) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cdec) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Walk registers and result payload.
	always_ff @(posedge clk) begin
		if (fin) begin
			status_q <= fin_st;
			probe_q  <= fin_probe;
		end
		if (start_walk) begin
			op_q     <= q_op;
			key_q    <= q_key;
			carry_q  <= q_key;
			home_q   <= q_home;
			idx_q    <= q_home;
			n_q      <= '0;
			commit_q <= 1'b0;
		end else if (restart) begin
			carry_q  <= key_q;
			idx_q    <= home_q;
			n_q      <= '0;
			commit_q <= 1'b1;
		end else if (adv) begin
			idx_q <= IW'(idx_q + 1'b1);
			n_q   <= n1;
			if (take_carry) begin
				carry_q <= key_a;
			end
		end else if (to_home) begin
			n_q <= n1;
		end
	end

	// Slot memories.
	always_ff @(posedge clk) begin
		if (state_q == olpt_pkg::BS_CLEAR) begin
			kind_mem[clr_q] <= olpt_pkg::KIND_EMPTY;
		end else if (wkind) begin
			kind_mem[idx_q] <= wkind_val;
		end
		if (wkey) begin
			key_mem[idx_q] <= carry_q;
		end
		kind_a <= kind_mem[rd_idx];
		kind_b <= kind_mem[rd_nxt];
		key_a  <= key_mem[rd_idx];
		key_b  <= key_mem[rd_nxt];
	end

	assign bstat.clearing = (state_q == olpt_pkg::BS_CLEAR);
	assign bstat.ready    = (state_q == olpt_pkg::BS_IDLE);
	assign done           = done_q;
	assign status         = status_q;
	assign probe_count    = probe_q;
	assign stored_count   = PW'(cnt_q);
endmodule

>>> rtl/core/ordered_linear_probe_table_top.sv
// Channel  | Handshake                    | Payload
// command  | start, accepted when !busy   | op, key
// result   | done, one-cycle strobe       | status, probe_count, stored_count
//
// A command waits in front-end stage one while its home slot is multiplied.
// The back end then pops it, reads the first slot and steps through the slots of its
// walk; done rises in the cycle after the last step. An insert that stores its key
// walks its run twice, and an erase that checks the following key's home slot adds
// a home step. A refused insert or an unused op finishes in the pop cycle.
// After reset the back end clears the slot kinds, one slot a cycle, over all
// HOME_SLOTS + OVERFLOW_SLOTS slots with busy held high.
// Busy also rises while the two-entry command queue is full or about to fill;
// results are never held.
module ordered_linear_probe_table_top #(
	parameter int HOME_SLOTS = 1024,
	parameter int OVERFLOW_SLOTS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [1:0]              op,
	input  logic [63:0]             key,
	output logic                    busy,
	output logic                    done,
	output logic [2:0]              status,
	output logic [olpt_pkg::PW-1:0] probe_count,
	output logic [olpt_pkg::PW-1:0] stored_count
);
	localparam int IW = $clog2(HOME_SLOTS + OVERFLOW_SLOTS);

	olpt_pkg::back_stat_t bstat;
	logic          pop;
	logic          q_valid;
	logic [1:0]    q_op;
	logic [63:0]   q_key;
	logic [IW-1:0] q_home;

	olpt_front #(.HOME_SLOTS(HOME_SLOTS), .IW(IW)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.op      (op),
		.key     (key),
		.bstat   (bstat),
		.pop     (pop),
		.busy    (busy),
		.q_valid (q_valid),
		.q_op    (q_op),
		.q_key   (q_key),
		.q_home  (q_home)
	);

	olpt_back #(
		.HOME_SLOTS     (HOME_SLOTS),
		.OVERFLOW_SLOTS (OVERFLOW_SLOTS),
		.IW             (IW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_op         (q_op),
		.q_key        (q_key),
		.q_home       (q_home),
		.pop          (pop),
		.bstat        (bstat),
		.done         (done),
		.status       (status),
		.probe_count  (probe_count),
		.stored_count (stored_count)
	);
endmodule
